// ----- sv/uds_pkg.sv -----
// Shared types, constants and helpers for the UTF-8 stream decoder.
package uds_pkg;

  localparam int unsigned CP_W  = 21;
  localparam int unsigned CNT_W = 16;

  localparam longint unsigned MAX_TEXT_BYTES = 64'd65536;
  localparam longint unsigned LIMIT_RAW =
    (MAX_TEXT_BYTES - 64'd1 < 64'd65535) ? (MAX_TEXT_BYTES - 64'd1) : 64'd65535;
  localparam logic [CNT_W-1:0] TEXT_LIMIT = CNT_W'(LIMIT_RAW);

  localparam logic [CP_W-1:0] REPL_RESET = 21'd65533;

  // Sequence lengths claimed by a lead byte; zero means an invalid lead.
  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_ONE  = 3'd1;
  localparam logic [2:0] LEN_TWO  = 3'd2;
  localparam logic [2:0] LEN_THREE = 3'd3;
  localparam logic [2:0] LEN_FOUR = 3'd4;

  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  // One input byte's worth of results: a run of replacements for held
  // bytes, optionally followed by one closing result.
  typedef struct packed {
    logic [1:0]       nrep;
    logic             has_tail;
    logic [CP_W-1:0]  tail_cp;
    logic             tail_rep;
    logic [CNT_W-1:0] tail_start;
    logic [CNT_W-1:0] seq_start;
    logic [CNT_W-1:0] base_idx;
    logic             eot;
  } uds_job_t;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [2:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {{(CNT_W-2){1'b0}}, b};
    return (s > {1'b0, TEXT_LIMIT}) ? TEXT_LIMIT : s[CNT_W-1:0];
  endfunction

endpackage

// ----- sv/utf8_stream_decoder.sv -----
// Top level of the lenient UTF-8 stream decoder.
//
// Input channel: one text byte per beat (data_byte_i, end_of_text_i), taken
// when in_valid_i is high and in_stall_o is low. Output channel: one code
// point per beat with its byte offset, character index and run/text flags,
// taken when out_valid_o is high and out_stall_i is low.
// A byte that completes a character or is plain ASCII goes into the job queue
// at the edge that takes it and from there into the output register. One byte
// is taken per cycle as long as each byte yields at most one result and the
// receiver does not stall; a byte that breaks a pending sequence yields up to
// four results, which the result sequencer emits one at a time. A four-entry
// job queue absorbs such bursts, so the input only stalls once it fills.
// When the receiver stalls, the output beat holds, the queue fills and then
// in_stall_o rises. Reset clears the decoder state, the queue and the output
// valid flag and sets the replacement code to U+FFFD; there is no clearing
// pass. cfg_we_i writes cfg_data_i as the replacement code; the user must
// assert it only while the block is idle, which the block does not enforce.
module utf8_stream_decoder
  import uds_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CP_W-1:0]  cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       data_byte_i,
  input  logic             end_of_text_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [CP_W-1:0]  code_point_o,
  output logic             is_replacement_o,
  output logic [CNT_W-1:0] start_offset_o,
  output logic [CNT_W-1:0] char_index_o,
  output logic             last_of_run_o,
  output logic             last_of_text_o
);

  logic [CP_W-1:0] repl_q;
  logic            accept;
  logic            push;
  uds_job_t        push_job;
  logic            full;
  logic            head_valid;
  uds_job_t        head_job;
  logic            pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repl_q <= REPL_RESET;
    end else if (cfg_we_i) begin
      repl_q <= cfg_data_i;
    end
  end

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  uds_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .data_byte_i   (data_byte_i),
    .end_of_text_i (end_of_text_i),
    .repl_code_i   (repl_q),
    .push_o        (push),
    .job_o         (push_job)
  );

  uds_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_job_i   (push_job),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_job_o   (head_job),
    .pop_i        (pop)
  );

  uds_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_valid_i     (head_valid),
    .head_job_i       (head_job),
    .pop_o            (pop),
    .repl_code_i      (repl_q),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .code_point_o     (code_point_o),
    .is_replacement_o (is_replacement_o),
    .start_offset_o   (start_offset_o),
    .char_index_o     (char_index_o),
    .last_of_run_o    (last_of_run_o),
    .last_of_text_o   (last_of_text_o)
  );

endmodule

// ----- sv/uds_front.sv -----
// Front end: classifies each byte, tracks the pending sequence, builds jobs.
module uds_front
  import uds_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      data_byte_i,
  input  logic            end_of_text_i,
  input  logic [CP_W-1:0] repl_code_i,
  output logic            push_o,
  output uds_job_t        job_o
);

  logic [2:0]       exp_len_q, exp_len_d;
  logic [1:0]       held_q, held_d;
  logic [CP_W-1:0]  partial_q, partial_d;
  logic [CNT_W-1:0] seq_q, seq_d;
  logic [CNT_W-1:0] pos_q, pos_d;
  logic [CNT_W-1:0] char_q, char_d;

  logic             cont;
  logic [2:0]       lead_len;
  logic [CP_W-1:0]  lead_bits;
  logic [2:0]       held_inc;
  logic [CP_W-1:0]  part_new;
  logic             decode_lead;
  uds_job_t         job;

  assign cont     = (data_byte_i & 8'hC0) == 8'h80;
  assign held_inc = {1'b0, held_q} + 3'd1;
  assign part_new = {partial_q[CP_W-7:0], data_byte_i[5:0]};

  always_comb begin
    if ((data_byte_i & 8'h80) == 8'h00) begin
      lead_len  = LEN_ONE;
      lead_bits = {13'd0, data_byte_i};
    end else if ((data_byte_i & 8'hE0) == 8'hC0) begin
      lead_len  = LEN_TWO;
      lead_bits = {16'd0, data_byte_i[4:0]};
    end else if ((data_byte_i & 8'hF0) == 8'hE0) begin
      lead_len  = LEN_THREE;
      lead_bits = {17'd0, data_byte_i[3:0]};
    end else if ((data_byte_i & 8'hF8) == 8'hF0) begin
      lead_len  = LEN_FOUR;
      lead_bits = {18'd0, data_byte_i[2:0]};
    end else begin
      lead_len  = LEN_NONE;
      lead_bits = '0;
    end
  end

  always_comb begin
    job            = '0;
    job.seq_start  = seq_q;
    job.base_idx   = char_q;
    job.eot        = end_of_text_i;
    decode_lead    = 1'b1;
    exp_len_d      = exp_len_q;
    held_d         = held_q;
    partial_d      = partial_q;
    seq_d          = seq_q;

    if (exp_len_q != LEN_NONE) begin
      if (cont) begin
        decode_lead = 1'b0;
        if (held_inc >= exp_len_q) begin
          job.has_tail   = 1'b1;
          job.tail_cp    = part_new;
          job.tail_rep   = 1'b0;
          job.tail_start = seq_q;
          exp_len_d      = LEN_NONE;
          held_d         = '0;
          partial_d      = '0;
        end else if (end_of_text_i) begin
          // Truncated at the end of the text: every held byte and this one are replaced.
          job.nrep = held_inc[1:0];
        end else begin
          held_d    = held_inc[1:0];
          partial_d = part_new;
        end
      end else begin
        job.nrep  = held_q;
        exp_len_d = LEN_NONE;
        held_d    = '0;
        partial_d = '0;
      end
    end

    if (decode_lead) begin
      if (lead_len == LEN_ONE) begin
        job.has_tail   = 1'b1;
        job.tail_cp    = lead_bits;
        job.tail_start = pos_q;
      end else if (lead_len == LEN_NONE || end_of_text_i) begin
        job.has_tail   = 1'b1;
        job.tail_cp    = repl_code_i;
        job.tail_rep   = 1'b1;
        job.tail_start = pos_q;
      end else begin
        exp_len_d = lead_len;
        held_d    = 2'd1;
        partial_d = lead_bits;
        seq_d     = pos_q;
      end
    end

    if (end_of_text_i) begin
      exp_len_d = LEN_NONE;
      held_d    = '0;
      partial_d = '0;
      seq_d     = '0;
      pos_d     = '0;
      char_d    = '0;
    end else begin
      pos_d  = sat_add(pos_q, 3'd1);
      char_d = sat_add(char_q, {1'b0, job.nrep} + {2'b00, job.has_tail});
    end
  end

  assign job_o  = job;
  assign push_o = accept_i && ((job.nrep != 2'd0) || job.has_tail);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_len_q <= LEN_NONE;
      held_q    <= '0;
      partial_q <= '0;
      seq_q     <= '0;
      pos_q     <= '0;
      char_q    <= '0;
    end else if (accept_i) begin
      exp_len_q <= exp_len_d;
      held_q    <= held_d;
      partial_q <= partial_d;
      seq_q     <= seq_d;
      pos_q     <= pos_d;
      char_q    <= char_d;
    end
  end

endmodule

// ----- sv/uds_queue.sv -----
// Small job queue between the front end and the result sequencer.
module uds_queue
  import uds_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  uds_job_t push_job_i,
  output logic     full_o,
  output logic     head_valid_o,
  output uds_job_t head_job_o,
  input  logic     pop_i
);

  localparam logic [QPTR_W-1:0] QLAST = QPTR_W'(QDEPTH - 1);
  localparam logic [QCNT_W-1:0] QFULL = QCNT_W'(QDEPTH);

  uds_job_t           mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  cnt_q, cnt_d;

  assign full_o       = cnt_q == QFULL;
  assign head_valid_o = cnt_q != '0;
  assign head_job_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QLAST) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QLAST) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

// ----- sv/uds_back.sv -----
// Back end: expands each job into result beats through an output register.
module uds_back
  import uds_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  uds_job_t         head_job_i,
  output logic             pop_o,
  input  logic [CP_W-1:0]  repl_code_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [CP_W-1:0]  code_point_o,
  output logic             is_replacement_o,
  output logic [CNT_W-1:0] start_offset_o,
  output logic [CNT_W-1:0] char_index_o,
  output logic             last_of_run_o,
  output logic             last_of_text_o
);

  logic [1:0]       k_q, k_d;
  logic             out_valid_q, out_valid_d;
  logic [CP_W-1:0]  cp_q;
  logic             rep_q;
  logic [CNT_W-1:0] start_q;
  logic [CNT_W-1:0] idx_q;
  logic             run_last_q;
  logic             text_last_q;

  logic             load;
  logic             is_flush;
  logic             last;
  logic [CP_W-1:0]  cur_cp;
  logic             cur_rep;
  logic [CNT_W-1:0] cur_start;

  assign load     = head_valid_i && (!out_valid_q || !out_stall_i);
  assign is_flush = k_q < head_job_i.nrep;

  always_comb begin
    if (is_flush) begin
      cur_cp    = repl_code_i;
      cur_rep   = 1'b1;
      cur_start = sat_add(head_job_i.seq_start, {1'b0, k_q});
      last      = ({1'b0, k_q} + 3'd1 == {1'b0, head_job_i.nrep}) && !head_job_i.has_tail;
    end else begin
      cur_cp    = head_job_i.tail_cp;
      cur_rep   = head_job_i.tail_rep;
      cur_start = head_job_i.tail_start;
      last      = 1'b1;
    end
  end

  assign pop_o = load && last;

  always_comb begin
    k_d = k_q;
    if (pop_o) begin
      k_d = '0;
    end else if (load) begin
      k_d = k_q + 2'd1;
    end
    if (load) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cp_q        <= cur_cp;
      rep_q       <= cur_rep;
      start_q     <= cur_start;
      idx_q       <= sat_add(head_job_i.base_idx, {1'b0, k_q});
      run_last_q  <= last;
      text_last_q <= last && head_job_i.eot;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign code_point_o     = cp_q;
  assign is_replacement_o = rep_q;
  assign start_offset_o   = start_q;
  assign char_index_o     = idx_q;
  assign last_of_run_o    = run_last_q;
  assign last_of_text_o   = text_last_q;

endmodule

// ----- sv/uds_checker.sv -----
// Port-level checks for the UTF-8 stream decoder and their binding.
module uds_checker
  import uds_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [CP_W-1:0]  code_point_o,
  input logic             is_replacement_o,
  input logic [CNT_W-1:0] char_index_o,
  input logic             last_of_run_o,
  input logic             last_of_text_o
);

  // A stalled output beat stays valid and keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(code_point_o))
    else $error("stalled output beat changed");

  // The end of a text always closes the run of its byte.
  a_text_closes_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_of_text_o |-> last_of_run_o)
    else $error("last_of_text without last_of_run");

  // Decoded characters always end their run; only replacements precede them.
  a_decoded_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_replacement_o |-> last_of_run_o)
    else $error("decoded character not last of its run");

  // Results of one run follow back to back with consecutive indexes, or an equal index where it saturates.
  a_run_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_of_run_o |=>
      out_valid_o && (char_index_o == $past(char_index_o) + 16'd1 ||
                      char_index_o == $past(char_index_o)))
    else $error("run of results broken");

endmodule

bind utf8_stream_decoder uds_checker u_uds_checker (.*);
